// ===== rtl/core/rwct_pkg.sv =====
// ----------------------------------------------------------------------------
// rwct_pkg
// Shared types and constants of the raycast wall column texturer.
// ----------------------------------------------------------------------------
`default_nettype none
package rwct_pkg;

   localparam int SCREEN_HEIGHT = 64;
   localparam int SCREEN_WIDTH  = 1024;
   localparam int HALF_HEIGHT   = SCREEN_HEIGHT / 2;
   localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
   localparam int COL_W         = 10;
   localparam int SIZE_W        = 9;
   localparam int HEIGHT_W      = $clog2(SCREEN_HEIGHT * 256) + 1;
   localparam int DVD_W         = 25;
   localparam int DVS_W         = 16;
   localparam int STEP_W        = 25;
   localparam int CFG_AW        = 3;

   // texture codes
   localparam logic [1:0] TEX_NORTH = 2'd0;
   localparam logic [1:0] TEX_SOUTH = 2'd1;
   localparam logic [1:0] TEX_EAST  = 2'd2;
   localparam logic [1:0] TEX_WEST  = 2'd3;

   // register indexes
   localparam logic REG_TEX_WIDTH  = 1'b0;
   localparam logic REG_TEX_HEIGHT = 1'b1;

   typedef struct packed {
      logic [SIZE_W-1:0] tex_w;
      logic [SIZE_W-1:0] tex_h;
   } cfg_type;

   typedef struct packed {
      logic [COL_W-1:0]  column;
      logic [1:0]        texture;
      logic [7:0]        tex_col;
      logic [ROW_W-1:0]  start_row;
      logic [ROW_W-1:0]  end_row;
      logic [31:0]       tex_pos;
      logic [STEP_W-1:0] tex_step;
   } span_type;

   typedef struct packed {
      logic push;
      logic full;
   } queue_wr_type;

   typedef enum logic [2:0] {
      FR_IDLE, FR_HIT, FR_TCOL, FR_DIV_H, FR_SPAN, FR_DIV_S, FR_POS, FR_PUSH
   } front_state_type;

   // clamp a texture size into 1..256
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) r = SIZE_W'(1);
      else if (v > SIZE_W'(256)) r = SIZE_W'(256);
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rwct_if.sv =====
// ----------------------------------------------------------------------------
// rwct_req_if / rwct_rsp_if
// Valid/ready channels for column requests and pixel results.
// ----------------------------------------------------------------------------
`default_nettype none
interface rwct_req_if;
   logic               valid;
   logic               ready;
   logic [9:0]         column;
   logic               side_hit;
   logic [15:0]        pos_x;
   logic [15:0]        pos_y;
   logic signed [15:0] ray_dir_x;
   logic signed [15:0] ray_dir_y;
   logic [15:0]        wall_distance;
   modport source (output valid, column, side_hit, pos_x, pos_y, ray_dir_x, ray_dir_y,
                   wall_distance, input ready);
   modport sink (input valid, column, side_hit, pos_x, pos_y, ray_dir_x, ray_dir_y,
                 wall_distance, output ready);
endinterface

interface rwct_rsp_if;
   logic       valid;
   logic       ready;
   logic [9:0] screen_column;
   logic [5:0] screen_row;
   logic [1:0] texture_select;
   logic [7:0] tex_col;
   logic [7:0] tex_row;
   logic       last;
   modport source (output valid, screen_column, screen_row, texture_select, tex_col,
                   tex_row, last, input ready);
   modport sink (input valid, screen_column, screen_row, texture_select, tex_col,
                 tex_row, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/raycast_wall_column_texturer.sv =====
// ----------------------------------------------------------------------------
// raycast_wall_column_texturer
// Textured wall column of a grid raycaster: one request in, one pixel per row.
// ----------------------------------------------------------------------------
// The first pixel of a column follows up to two 25-step passes of the shared
// one-bit-per-cycle divider (height, then texture step).
// Pixels: one per cycle while the receiver is ready, once a span is loaded;
// front and back work on different columns, overlapped by the queue.
// Reset: synchronous, active high; texture sizes return to 64, queue empties.
`default_nettype none
module raycast_wall_column_texturer import rwct_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   rwct_req_if.sink               req_bus,
   rwct_rsp_if.source             rsp_bus,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CFG_AW-1:0] csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   cfg_type      cfg_ff;
   queue_wr_type qwr;
   span_type     span_w, span_r;
   logic         q_full, q_not_empty, q_pop;

   // configuration registers
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tex_w <= SIZE_W'(64);
         cfg_ff.tex_h <= SIZE_W'(64);
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[2])
            REG_TEX_WIDTH:  cfg_ff.tex_w <= csr_pwdata[SIZE_W-1:0];
            REG_TEX_HEIGHT: cfg_ff.tex_h <= csr_pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end
   assign csr_prdata = (csr_paddr[2] == REG_TEX_HEIGHT) ? 32'(cfg_ff.tex_h) : 32'(cfg_ff.tex_w);

   rwct_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_bus    (req_bus),
      .qwr_out    (qwr),
      .queue_full (q_full),
      .span       (span_w)
   );

   rwct_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .qwr       (qwr),
      .wr_data   (span_w),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop       (q_pop),
      .rd_data   (span_r)
   );

   rwct_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .not_empty (q_not_empty),
      .pop       (q_pop),
      .span_in   (span_r),
      .rsp_bus   (rsp_bus)
   );

   // a column keeps going until its last pixel
   a_column_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && !rsp_bus.last |=> rsp_bus.valid)
      else $error("column ended before last pixel");

   a_row_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && !rsp_bus.last |=>
      rsp_bus.screen_row == $past(rsp_bus.screen_row) + 6'd1)
      else $error("screen row did not advance by one");

   a_column_held: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && !rsp_bus.last |=>
      rsp_bus.screen_column == $past(rsp_bus.screen_column))
      else $error("screen column changed inside a column");

   a_no_pop_when_busy: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty && !rsp_bus.valid)
      else $error("span popped while a column is active");
endmodule
`default_nettype wire

// ===== rtl/core/rwct_div.sv =====
// ----------------------------------------------------------------------------
// rwct_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rwct_div import rwct_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DVD_W-1:0]  dividend,
   input  wire logic [DVS_W-1:0]  divisor,
   output logic                   done,
   output logic [DVD_W-1:0]       quotient
);
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;

   // one shift-subtract step
   always_comb begin
      trial    = {rem_ff, quo_ff[DVD_W-1]};
      diff     = trial - {1'b0, dvs_ff};
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         count_in = CNT_W'(DVD_W);
         rem_in   = '0;
         quo_in   = dividend;
         dvs_in   = divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - CNT_W'(1);
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   // done on the last step
   assign done     = (count_ff == CNT_W'(1));
   assign quotient = {quo_ff[DVD_W-2:0], (trial >= {1'b0, dvs_ff})};
endmodule
`default_nettype wire

// ===== rtl/core/rwct_front.sv =====
// ----------------------------------------------------------------------------
// rwct_front
// Takes a column request and works out texture, span, texel column and step.
// ----------------------------------------------------------------------------
`default_nettype none
module rwct_front import rwct_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   rwct_req_if.sink     req_bus,
   output queue_wr_type qwr_out,
   input  wire logic    queue_full,
   output span_type     span
);
   front_state_type state_ff, state_in;

   logic [COL_W-1:0]    col_ff;
   logic [1:0]          tex_ff;
   logic [9:0]          coord_ff;
   logic signed [15:0]  dir_ff;
   logic [15:0]         dist_ff;
   logic [21:0]         frac_ff;
   logic [7:0]          tcol_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [ROW_W-1:0]    start_ff, end_ff;
   logic [13:0]         offset_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [31:0]         pos_ff;

   logic                accept;
   logic                div_start, div_done;
   logic [DVD_W-1:0]    div_dvd, div_q;
   logic [DVS_W-1:0]    div_dvs;
   logic signed [32:0]  hit_prod;
   logic [30:0]         tcol_prod;
   logic [38:0]         pos_prod;
   logic [13:0]         half_h;
   logic [SIZE_W-1:0]   tw, th;

   assign tw     = clamp_size(cfg.tex_w);
   assign th     = clamp_size(cfg.tex_h);
   assign accept = req_bus.valid && req_bus.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FR_IDLE:  if (accept && ({1'b0, req_bus.column} < 11'(SCREEN_WIDTH)))
                      state_in = FR_HIT;
         FR_HIT:   state_in = FR_TCOL;
         FR_TCOL:  state_in = FR_DIV_H;
         FR_DIV_H: if (div_done) state_in = FR_SPAN;
         FR_SPAN:  state_in = (height_ff == '0) ? FR_POS : FR_DIV_S;
         FR_DIV_S: if (div_done) state_in = FR_POS;
         FR_POS:   state_in = (start_ff < end_ff) ? FR_PUSH : FR_IDLE;
         FR_PUSH:  if (!queue_full) state_in = FR_IDLE;
         default:  state_in = FR_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_bus.ready = (state_ff == FR_IDLE);
      div_start     = (state_ff == FR_TCOL) || (state_ff == FR_SPAN && height_ff != '0);
      qwr_out.push  = (state_ff == FR_PUSH) && !queue_full;
      qwr_out.full  = queue_full;
   end

   // divider operands: height first, then texture step
   always_comb begin
      if (state_ff == FR_TCOL) begin
         div_dvd = DVD_W'(SCREEN_HEIGHT * 256);
         div_dvs = (dist_ff == '0) ? DVS_W'(1) : dist_ff;
      end else begin
         div_dvd = {th, 16'h0000};
         div_dvs = DVS_W'(height_ff);
      end
   end

   rwct_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_q)
   );

   assign hit_prod  = $signed({1'b0, dist_ff}) * dir_ff;
   assign tcol_prod = frac_ff * tw;
   assign pos_prod  = offset_ff * step_ff;
   assign half_h    = height_ff[HEIGHT_W-1:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         col_ff  <= req_bus.column;
         dist_ff <= req_bus.wall_distance;
         if (!req_bus.side_hit) begin
            tex_ff   <= req_bus.ray_dir_x[15] ? TEX_EAST : TEX_WEST;
            coord_ff <= req_bus.pos_y[9:0];
            dir_ff   <= req_bus.ray_dir_y;
         end else begin
            tex_ff   <= req_bus.ray_dir_y[15] ? TEX_NORTH : TEX_SOUTH;
            coord_ff <= req_bus.pos_x[9:0];
            dir_ff   <= req_bus.ray_dir_x;
         end
      end
      if (state_ff == FR_HIT) frac_ff <= {coord_ff, 12'h000} + hit_prod[21:0];
      if (state_ff == FR_TCOL) tcol_ff <= tcol_prod[29:22];
      if (state_ff == FR_DIV_H && div_done) height_ff <= div_q[HEIGHT_W-1:0];
      if (state_ff == FR_SPAN) begin
         start_ff  <= (half_h >= 14'(HALF_HEIGHT)) ? '0
                      : ROW_W'(HALF_HEIGHT) - half_h[ROW_W-1:0];
         end_ff    <= (half_h >= 14'(HALF_HEIGHT - 1)) ? ROW_W'(SCREEN_HEIGHT - 1)
                      : ROW_W'(HALF_HEIGHT) + half_h[ROW_W-1:0];
         offset_ff <= (half_h > 14'(HALF_HEIGHT)) ? half_h - 14'(HALF_HEIGHT) : '0;
         if (height_ff == '0) step_ff <= '0;
      end
      if (state_ff == FR_DIV_S && div_done) step_ff <= div_q;
      if (state_ff == FR_POS) pos_ff <= (|pos_prod[38:32]) ? 32'hFFFF_FFFF : pos_prod[31:0];
   end

   assign span.column    = col_ff;
   assign span.texture   = tex_ff;
   assign span.tex_col   = tcol_ff;
   assign span.start_row = start_ff;
   assign span.end_row   = end_ff;
   assign span.tex_pos   = pos_ff;
   assign span.tex_step  = step_ff;
endmodule
`default_nettype wire

// ===== rtl/core/rwct_queue.sv =====
// ----------------------------------------------------------------------------
// rwct_queue
// Two-entry queue of column spans between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module rwct_queue import rwct_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire queue_wr_type qwr,
   input  wire span_type     wr_data,
   output logic              full,
   output logic              not_empty,
   input  wire logic         pop,
   output span_type          rd_data
);
   span_type   mem_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] count_ff;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign rd_data   = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         if (qwr.push) wptr_ff <= ~wptr_ff;
         if (pop) rptr_ff <= ~rptr_ff;
         count_ff <= count_ff + 2'(qwr.push) - 2'(pop);
      end
      if (qwr.push) mem_ff[wptr_ff] <= wr_data;
   end
endmodule
`default_nettype wire

// ===== rtl/core/rwct_back.sv =====
// ----------------------------------------------------------------------------
// rwct_back
// Walks a span row by row and emits one pixel result per row.
// ----------------------------------------------------------------------------
`default_nettype none
module rwct_back import rwct_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     not_empty,
   output logic          pop,
   input  wire span_type span_in,
   rwct_rsp_if.source    rsp_bus
);
   logic              active_ff;
   span_type          cur_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [SIZE_W-1:0] th;
   logic [8:0]        th_max;
   logic [32:0]       pos_sum;
   logic              last_row;
   logic              take;

   assign th       = clamp_size(cfg.tex_h);
   assign th_max   = th - 9'd1;
   assign pop      = !active_ff && not_empty;
   assign take     = rsp_bus.valid && rsp_bus.ready;
   assign last_row = (row_ff + ROW_W'(1) == cur_ff.end_row);
   assign pos_sum  = {1'b0, cur_ff.tex_pos} + 33'(cur_ff.tex_step);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (pop) begin
         active_ff <= 1'b1;
      end else if (take && last_row) begin
         active_ff <= 1'b0;
      end
      // load a span, then step the texture position on each accepted pixel
      if (pop) begin
         cur_ff <= span_in;
         row_ff <= span_in.start_row;
      end else if (take) begin
         row_ff         <= row_ff + ROW_W'(1);
         cur_ff.tex_pos <= pos_sum[32] ? 32'hFFFF_FFFF : pos_sum[31:0];
      end
   end

   // result payload
   always_comb begin
      rsp_bus.valid          = active_ff;
      rsp_bus.screen_column  = cur_ff.column;
      rsp_bus.screen_row     = 6'(row_ff);
      rsp_bus.texture_select = cur_ff.texture;
      rsp_bus.tex_col        = cur_ff.tex_col;
      rsp_bus.tex_row        = ({1'b0, cur_ff.tex_pos[31:16]} > {8'h00, th_max}) ?
                               th_max[7:0] : cur_ff.tex_pos[23:16];
      rsp_bus.last           = last_row;
   end
endmodule
`default_nettype wire

// ===== bench/raycast_wall_column_texturer_test.sv =====
// ----------------------------------------------------------------------------
// raycast_wall_column_texturer_test
// Self-checking bench for the wall column texturer: column requests go in,
// and every pixel that comes out is checked against a column predictor.
// Texture size settings, idle patterns on both channels and a long output
// hold-off are applied across the run.
// ----------------------------------------------------------------------------
module raycast_wall_column_texturer_test;
   import rwct_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [9:0]         column;
      logic               side_hit;
      logic [15:0]        pos_x;
      logic [15:0]        pos_y;
      logic signed [15:0] ray_dir_x;
      logic signed [15:0] ray_dir_y;
      logic [15:0]        wall_distance;
   } column_req_t;

   typedef struct {
      logic [9:0] screen_column;
      logic [5:0] screen_row;
      logic [1:0] texture_select;
      logic [7:0] tex_col;
      logic [7:0] tex_row;
      logic       last;
   } pixel_t;

   // column predictor and store of expected pixels
   class pixel_scoreboard;
      pixel_t     expected_pixels[$];
      logic [8:0] tex_width_reg  = 9'd64;
      logic [8:0] tex_height_reg = 9'd64;
      int         errors = 0;

      task report(string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      function longint unsigned clamp(logic [8:0] v);
         if (v == 0) return 1;
         if (v > 256) return 256;
         return v;
      endfunction

      // expand one column request into its pixels
      function void note_column(column_req_t r);
         longint                tw, th, height, span_start, span_end, hit, wdist, row;
         longint unsigned       frac, tstep, tpos, trow;
         logic [1:0]            tex;
         logic [7:0]            tcol;
         pixel_t                p;
         tw    = clamp(tex_width_reg);
         th    = clamp(tex_height_reg);
         wdist = r.wall_distance;
         if (r.side_hit == 1'b0) tex = (r.ray_dir_x < 0) ? TEX_EAST : TEX_WEST;
         else tex = (r.ray_dir_y < 0) ? TEX_NORTH : TEX_SOUTH;
         height = (wdist == 0) ? SCREEN_HEIGHT * 256 : (SCREEN_HEIGHT * 256) / wdist;
         span_start = HALF_HEIGHT - height / 2;
         if (span_start < 0) span_start = 0;
         span_end = HALF_HEIGHT + height / 2;
         if (span_end >= SCREEN_HEIGHT) span_end = SCREEN_HEIGHT - 1;
         // hit coordinate in Q.22, fraction keeps the low 22 bits
         if (r.side_hit == 1'b0) hit = longint'(r.pos_y) * 4096 + wdist * longint'(r.ray_dir_y);
         else hit = longint'(r.pos_x) * 4096 + wdist * longint'(r.ray_dir_x);
         frac  = longint'(hit) & 64'h3FFFFF;
         tcol  = 8'((frac * tw) >> 22);
         tstep = (height > 0) ? (th << 16) / height : 0;
         tpos  = longint'(span_start - HALF_HEIGHT + height / 2) * tstep;
         if (tpos > 64'hFFFFFFFF) tpos = 64'hFFFFFFFF;
         for (row = span_start; row < span_end; row++) begin
            trow = tpos >> 16;
            if (trow > th - 1) trow = th - 1;
            p.screen_column  = r.column;
            p.screen_row     = 6'(row);
            p.texture_select = tex;
            p.tex_col        = tcol;
            p.tex_row        = 8'(trow);
            p.last           = (row + 1 == span_end);
            expected_pixels.push_back(p);
            tpos = tpos + tstep;
            if (tpos > 64'hFFFFFFFF) tpos = 64'hFFFFFFFF;
         end
      endfunction

      task check_pixel(pixel_t got);
         pixel_t e;
         if (expected_pixels.size() == 0) begin
            report($sformatf("unexpected pixel col %0d row %0d", got.screen_column,
                             got.screen_row));
            return;
         end
         e = expected_pixels.pop_front();
         if (got.screen_column !== e.screen_column)
            report($sformatf("screen_column %0d exp %0d", got.screen_column, e.screen_column));
         if (got.screen_row !== e.screen_row)
            report($sformatf("screen_row %0d exp %0d", got.screen_row, e.screen_row));
         if (got.texture_select !== e.texture_select)
            report($sformatf("texture_select %0d exp %0d", got.texture_select,
                             e.texture_select));
         if (got.tex_col !== e.tex_col)
            report($sformatf("tex_col %0d exp %0d (col %0d)", got.tex_col, e.tex_col,
                             e.screen_column));
         if (got.tex_row !== e.tex_row)
            report($sformatf("tex_row %0d exp %0d (col %0d row %0d)", got.tex_row,
                             e.tex_row, e.screen_column, e.screen_row));
         if (got.last !== e.last)
            report($sformatf("last %0d exp %0d", got.last, e.last));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CFG_AW-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   rwct_req_if req_bus();
   rwct_rsp_if rsp_bus();

   raycast_wall_column_texturer i_dut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   pixel_scoreboard sb = new();
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_off = 1'b0;
   longint cycle_count = 0;

   always #4 clock = ~clock;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.column = '0;
      req_bus.side_hit = 1'b0;
      req_bus.pos_x = '0;
      req_bus.pos_y = '0;
      req_bus.ray_dir_x = '0;
      req_bus.ray_dir_y = '0;
      req_bus.wall_distance = '0;
      rsp_bus.ready = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 1500000) begin
         $display("Verification failed");
         $finish;
      end
   end

   // result side: ready driven at the falling edge
   always @(negedge clock) begin
      if (reset || hold_off) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // result side: pixels sampled at the rising edge
   always @(posedge clock) begin
      pixel_t got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.screen_column  = rsp_bus.screen_column;
         got.screen_row     = rsp_bus.screen_row;
         got.texture_select = rsp_bus.texture_select;
         got.tex_col        = rsp_bus.tex_col;
         got.tex_row        = rsp_bus.tex_row;
         got.last           = rsp_bus.last;
         sb.check_pixel(got);
      end
   end

   // register write, setup then access
   task write_reg(logic idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CFG_AW'({idx, 2'b00});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_TEX_WIDTH) sb.tex_width_reg = value[8:0];
      else sb.tex_height_reg = value[8:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // offer one column request, called at a falling edge
   task send_column(column_req_t r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.column        <= r.column;
      req_bus.side_hit      <= r.side_hit;
      req_bus.pos_x         <= r.pos_x;
      req_bus.pos_y         <= r.pos_y;
      req_bus.ray_dir_x     <= r.ray_dir_x;
      req_bus.ray_dir_y     <= r.ray_dir_y;
      req_bus.wall_distance <= r.wall_distance;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_column(r);
      @(negedge clock);
   endtask

   task send_random_column();
      column_req_t r;
      r.column    = 10'($urandom_range(0, 1023));
      r.side_hit  = 1'($urandom);
      r.pos_x     = 16'($urandom);
      r.pos_y     = 16'($urandom);
      r.ray_dir_x = 16'($urandom);
      r.ray_dir_y = 16'($urandom);
      case ($urandom_range(9))
         7:       r.wall_distance = 16'($urandom_range(0, 255));
         8:       r.wall_distance = 16'($urandom);
         9:       r.wall_distance = 16'd0;
         default: r.wall_distance = 16'($urandom_range(128, 2048));
      endcase
      send_column(r);
   endtask

   // wait until all pixels are out and the front end has drained
   task drain();
      req_bus.valid <= 1'b0;
      while (sb.expected_pixels.size() > 0) @(posedge clock);
      repeat (120) @(posedge clock);
      @(negedge clock);
   endtask

   task run_phase(logic [31:0] tw, logic [31:0] th, int n, int sidle, int rstall);
      write_reg(REG_TEX_WIDTH, tw);
      write_reg(REG_TEX_HEIGHT, th);
      send_idle_pct  = sidle;
      recv_stall_pct = rstall;
      repeat (n) send_random_column();
      drain();
   endtask

   initial begin
      column_req_t d;
      logic [15:0] dists[8];
      dists = '{16'd0, 16'd1, 16'd255, 16'd256, 16'd257, 16'd512, 16'd16384, 16'hFFFF};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed columns at reset texture sizes
      foreach (dists[i]) begin
         d.column        = (i % 2) ? 10'd1023 : 10'd0;
         d.side_hit      = i[0];
         d.pos_x         = (i % 3 == 0) ? 16'hFFFF : 16'h0000;
         d.pos_y         = (i % 3 == 1) ? 16'hFFFF : 16'h0000;
         d.ray_dir_x     = i[1] ? 16'sh8000 : 16'sh7FFF;
         d.ray_dir_y     = i[2] ? 16'sh7FFF : 16'sh8000;
         d.wall_distance = dists[i];
         send_column(d);
      end
      for (int i = 0; i < 8; i++) begin
         d.column        = 10'(i * 131);
         d.side_hit      = i[0];
         d.pos_x         = 16'h03FF + 16'(i);
         d.pos_y         = 16'hFC00 - 16'(i);
         d.ray_dir_x     = i[1] ? -16'sd1 : 16'sd0;
         d.ray_dir_y     = i[2] ? -16'sd1 : 16'sd0;
         d.wall_distance = 16'd300 + 16'(i * 100);
         send_column(d);
      end
      drain();

      // random phases across texture sizes and idle patterns
      run_phase(32'd1, 32'd1, 130, 36, 81);
      run_phase(32'd256, 32'd256, 130, 81, 36);
      run_phase(32'd0, 32'h1FF, 40, 0, 0);
      // long output hold-off while requests keep coming
      fork
         begin
            hold_off = 1'b1;
            repeat (3000) @(posedge clock);
            hold_off = 1'b0;
         end
      join_none
      run_phase(32'd37, 32'd200, 100, 0, 0);

      if (sb.expected_pixels.size() > 0)
         sb.report($sformatf("%0d pixels never arrived", sb.expected_pixels.size()));
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
